// ===== rtl/tug_pkg.sv =====
// Shared types and constants for the tile upscaler with grout grid.
// No dependencies; imported by tile_upscale_with_grout_grid and its testbench.
`timescale 1ns / 1ps

package tug_pkg;

   typedef enum logic [1:0] {
      CSR_TILE_SIZE  = 2'd0,
      CSR_SRC_WIDTH  = 2'd1,
      CSR_SRC_HEIGHT = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam logic       MODE_LOAD   = 1'b0;
   localparam logic       MODE_EMIT   = 1'b1;
   localparam logic [7:0] GROUT_COLOR = 8'h00;
   localparam int         NUM_COLORS  = 3;

   localparam logic [4:0]  TILE_RESET   = 5'd8;
   localparam logic [10:0] WIDTH_RESET  = 11'd64;
   localparam logic [10:0] HEIGHT_RESET = 11'd64;
   localparam logic [10:0] DIM_MAX      = 11'd1024;
   localparam logic [4:0]  TILE_MAX     = 5'd16;

   typedef struct packed {
      logic grout;
      logic row_end;
      logic frame_end;
   } flags_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][7:0] rgb;
      flags_type                  flags;
   } pixel_type;

endpackage

// ===== rtl/tug_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the source line store.
`timescale 1ns / 1ps

module tug_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tile_upscale_with_grout_grid.sv =====
// Top level of the integer tile upscaler with black grout grid.
// Depends on tug_pkg and tug_ram.
`timescale 1ns / 1ps

// Usage:
//  req_* : one transaction per item. mode 0 loads a source pixel into the line
//          store at req_column (columns at or beyond the width are dropped).
//          mode 1 emits the next output pixel in raster order.
//  rsp_* : one transaction per emit, in order; loads give none.
//  csr_* : write-only register port (tile size, source width, source height).
//          A write to tile size, width or height restarts the frame counters; the
//          line store keeps its contents. Write only while the block is idle.
//  An accepted emit goes through the registered line-store read and then the
//  output queue before it shows on rsp_*.
//  Throughput: one item per cycle, loads and emits alike, while req_stall is low. A
//  load written at one edge is visible to an emit accepted at the next edge.
//  A four-entry output queue absorbs rsp_stall; req_stall rises only when the
//  queue plus the read in flight would otherwise overflow.
//  Reset: registers return to tile 8, 64 x 64, counters to the frame origin.
//  There is no clearing pass; line-store entries are undefined until loaded.

module tile_upscale_with_grout_grid #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [9:0]  req_column,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_is_grout,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   input  logic        csr_we,
   input  tug_pkg::csr_index_type csr_index,
   input  logic [10:0] csr_wdata
);

   import tug_pkg::*;

   localparam int          AW        = $clog2(MAX_WIDTH);
   localparam logic [12:0] MAX_W     = 13'(MAX_WIDTH);
   localparam int          QDEPTH    = 4;
   localparam int          QPW       = $clog2(QDEPTH);

   // configuration
   logic [4:0]  tile_ff, tile_in;
   logic [10:0] width_ff, width_in;
   logic [10:0] height_ff, height_in;
   logic [4:0]  k_ff, k_in;
   logic [10:0] w_ff, w_in;
   logic [14:0] wo_last_ff, wo_last_in;
   logic [14:0] ho_last_ff, ho_last_in;
   logic [14:0] wo_mk_ff, wo_mk_in;
   logic [14:0] ho_mk_ff, ho_mk_in;
   logic [10:0] wd, hd;
   logic [15:0] wo, ho;

   always_comb begin
      tile_in   = tile_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (reset) begin
         tile_in   = TILE_RESET;
         width_in  = WIDTH_RESET;
         height_in = HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TILE_SIZE:  tile_in   = csr_wdata[4:0];
            CSR_SRC_WIDTH:  width_in  = csr_wdata;
            CSR_SRC_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (tile_in == 5'd0) k_in = 5'd1;
      else if (tile_in > TILE_MAX) k_in = TILE_MAX;
      else k_in = tile_in;

      if (width_in == 11'd0) wd = 11'd1;
      else if (width_in > DIM_MAX) wd = DIM_MAX;
      else wd = width_in;
      if ({2'b00, wd} > MAX_W) w_in = MAX_W[10:0];
      else w_in = wd;

      if (height_in == 11'd0) hd = 11'd1;
      else if (height_in > DIM_MAX) hd = DIM_MAX;
      else hd = height_in;

      wo = 16'(w_in) * 16'(k_in);
      ho = 16'(hd) * 16'(k_in);
      wo_last_in = 15'(wo - 16'd1);
      ho_last_in = 15'(ho - 16'd1);
      wo_mk_in   = 15'(wo - 16'(k_in));
      ho_mk_in   = 15'(ho - 16'(k_in));
   end

   always_ff @(posedge clock) begin
      tile_ff    <= tile_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      k_ff       <= k_in;
      w_ff       <= w_in;
      wo_last_ff <= wo_last_in;
      ho_last_ff <= ho_last_in;
      wo_mk_ff   <= wo_mk_in;
      ho_mk_ff   <= ho_mk_in;
   end

   // raster counters
   logic [13:0] out_row_ff, out_row_in;
   logic [13:0] out_col_ff, out_col_in;
   logic [3:0]  row_phase_ff, row_phase_in;
   logic [3:0]  col_phase_ff, col_phase_in;
   logic [9:0]  src_col_ff, src_col_in;

   logic      accept, emit, load;
   logic      load_ok;
   logic      csr_restart;
   flags_type flags;
   logic [4:0] row_phase_inc, col_phase_inc;

   assign accept = req_valid && !req_stall;
   assign emit   = accept && (req_mode == MODE_EMIT);
   assign load   = accept && (req_mode == MODE_LOAD);
   assign load_ok = {3'b000, req_column} < {2'b00, w_ff};
   assign csr_restart = csr_we && (csr_index != CSR_UNUSED);

   assign row_phase_inc = {1'b0, row_phase_ff} + 5'd1;
   assign col_phase_inc = {1'b0, col_phase_ff} + 5'd1;

   always_comb begin
      flags.row_end   = {1'b0, out_col_ff} >= wo_last_ff;
      flags.frame_end = flags.row_end && ({1'b0, out_row_ff} >= ho_last_ff);
      flags.grout     = (out_row_ff == 14'd0) || ({1'b0, out_row_ff} == ho_last_ff)
                     || (out_col_ff == 14'd0) || ({1'b0, out_col_ff} == wo_last_ff)
                     || ((row_phase_ff == 4'd0) && ({1'b0, out_row_ff} <= ho_mk_ff))
                     || ((col_phase_ff == 4'd0) && ({1'b0, out_col_ff} <= wo_mk_ff));

      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      row_phase_in = row_phase_ff;
      col_phase_in = col_phase_ff;
      src_col_in   = src_col_ff;
      if (flags.row_end) begin
         out_col_in   = 14'd0;
         col_phase_in = 4'd0;
         src_col_in   = 10'd0;
         if (flags.frame_end) begin
            out_row_in   = 14'd0;
            row_phase_in = 4'd0;
         end else begin
            out_row_in   = out_row_ff + 14'd1;
            row_phase_in = (row_phase_inc >= k_ff) ? 4'd0 : row_phase_inc[3:0];
         end
      end else begin
         out_col_in = out_col_ff + 14'd1;
         if (col_phase_inc >= k_ff) begin
            col_phase_in = 4'd0;
            src_col_in   = src_col_ff + 10'd1;
         end else begin
            col_phase_in = col_phase_inc[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
         src_col_ff   <= '0;
      end else if (emit) begin
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
         src_col_ff   <= src_col_in;
      end
   end

   // line store
   logic [12:0]   wr_addr_ext, rd_addr_ext;
   logic [23:0]   rd_data;

   assign wr_addr_ext = {3'b000, req_column};
   assign rd_addr_ext = {3'b000, src_col_ff};

   tug_ram #(
      .WIDTH (24),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (load && load_ok),
      .wr_addr (wr_addr_ext[AW-1:0]),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (emit),
      .rd_addr (rd_addr_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   // read stage
   logic      s1_vld_ff;
   flags_type s1_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= emit;
      end
      s1_flags_ff <= flags;
   end

   pixel_type push_px;

   always_comb begin
      push_px.flags = s1_flags_ff;
      if (s1_flags_ff.grout) begin
         push_px.rgb = {NUM_COLORS{GROUT_COLOR}};
      end else begin
         push_px.rgb = rd_data;
      end
   end

   // output queue
   pixel_type         queue_ff [QDEPTH];
   logic [QPW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QPW:0]      count_ff, count_in;
   logic              push, pop;
   pixel_type         head;

   assign push = s1_vld_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_px;
      end
   end

   assign head      = queue_ff[rd_ptr_ff];
   assign req_stall = (count_ff + {{QPW{1'b0}}, s1_vld_ff}) >= (QPW+1)'(QDEPTH);
   assign rsp_valid = (count_ff != '0);

   assign rsp_red_out   = head.rgb[2];
   assign rsp_green_out = head.rgb[1];
   assign rsp_blue_out  = head.rgb[0];
   assign rsp_is_grout  = head.flags.grout;
   assign rsp_row_end   = head.flags.row_end;
   assign rsp_frame_end = head.flags.frame_end;

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == (QPW+1)'(QDEPTH))))
      else $error("output queue overflow");

   a_s1_from_emit: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(req_valid && !req_stall && (req_mode == MODE_EMIT)))
      else $error("read stage valid without an emit transaction");

   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   a_grout_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_grout |-> (rsp_red_out == GROUT_COLOR)
         && (rsp_green_out == GROUT_COLOR) && (rsp_blue_out == GROUT_COLOR))
      else $error("grout pixel not black");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      csr_restart |=> (out_row_ff == 14'd0) && (out_col_ff == 14'd0) && (src_col_ff == 10'd0))
      else $error("register write did not restart the frame");

endmodule

// ===== tb/sv/tile_upscale_with_grout_grid_tb.sv =====
// Self-checking testbench for tile_upscale_with_grout_grid: drives load and
// emit transactions, predicts every output pixel and checks it field by field.
// Depends on tug_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tile_upscale_with_grout_grid_tb;
   import tug_pkg::*;

   localparam int ITEM_TARGET   = 850;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int STORE_DEPTH   = 1024;

   typedef struct {
      logic [7:0] red, green, blue;
      logic       grout, row_end, frame_end;
   } out_pixel_type;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_stall;
   logic          req_mode     = MODE_LOAD;
   logic [9:0]    req_column   = '0;
   logic [7:0]    req_red_in   = '0;
   logic [7:0]    req_green_in = '0;
   logic [7:0]    req_blue_in  = '0;
   logic          rsp_valid;
   logic          rsp_stall    = 1'b0;
   logic [7:0]    rsp_red_out;
   logic [7:0]    rsp_green_out;
   logic [7:0]    rsp_blue_out;
   logic          rsp_is_grout;
   logic          rsp_row_end;
   logic          rsp_frame_end;
   logic          csr_we       = 1'b0;
   csr_index_type csr_index    = CSR_TILE_SIZE;
   logic [10:0]   csr_wdata    = '0;

   logic [4:0]    cfg_tile;
   logic [10:0]   cfg_width;
   logic [10:0]   cfg_height;
   int unsigned   pos_row, pos_col, ph_row, ph_col, col_src;
   logic [23:0]   source_row [STORE_DEPTH];
   bit            row_loaded [STORE_DEPTH];
   out_pixel_type pending_pixels [$];

   int unsigned   error_count    = 0;
   int unsigned   items_sent     = 0;
   int unsigned   pixels_checked = 0;
   int unsigned   cycle_count    = 0;
   int unsigned   send_idle_pct  = 25;
   int unsigned   recv_idle_pct  = 82;

   tile_upscale_with_grout_grid uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_column    (req_column),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_is_grout  (rsp_is_grout),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned tile_k();
      return clamp(cfg_tile, TILE_MAX);
   endfunction

   function automatic int unsigned width_eff();
      return clamp(clamp(cfg_width, DIM_MAX), STORE_DEPTH);
   endfunction

   function automatic int unsigned height_eff();
      return clamp(cfg_height, DIM_MAX);
   endfunction

   function automatic void restart_frame();
      pos_row = 0;
      pos_col = 0;
      ph_row  = 0;
      ph_col  = 0;
      col_src = 0;
   endfunction

   // Computes the next raster pixel and advances the frame position.
   function automatic out_pixel_type advance_output_pixel();
      int unsigned   k, wo, ho;
      logic [23:0]   rgb;
      out_pixel_type px;
      k   = tile_k();
      wo  = width_eff() * k;
      ho  = height_eff() * k;
      rgb = source_row[col_src];
      px.grout = (pos_row == 0) || (pos_row == ho - 1) || (pos_col == 0)
              || (pos_col == wo - 1) || (ph_row == 0 && pos_row + k <= ho)
              || (ph_col == 0 && pos_col + k <= wo);
      px.red       = px.grout ? GROUT_COLOR : rgb[23:16];
      px.green     = px.grout ? GROUT_COLOR : rgb[15:8];
      px.blue      = px.grout ? GROUT_COLOR : rgb[7:0];
      px.row_end   = (pos_col >= wo - 1);
      px.frame_end = px.row_end && (pos_row >= ho - 1);
      if (px.row_end) begin
         pos_col = 0;
         ph_col  = 0;
         col_src = 0;
         if (px.frame_end) begin
            pos_row = 0;
            ph_row  = 0;
         end else begin
            pos_row = (pos_row + 1) & 32'h3FFF;
            ph_row  = (ph_row + 1 >= k) ? 0 : ph_row + 1;
         end
      end else begin
         pos_col = (pos_col + 1) & 32'h3FFF;
         if (ph_col + 1 >= k) begin
            ph_col  = 0;
            col_src = (col_src + 1) & 32'h3FF;
         end else begin
            ph_col = ph_col + 1;
         end
      end
      return px;
   endfunction

   function automatic logic [10:0] random_tile_word();
      logic [10:0] v;
      v = 11'($urandom());
      case ($urandom_range(9))
         0:       v[4:0] = 5'd0;
         1:       v[4:0] = TILE_MAX;
         2:       v[4:0] = 5'($urandom_range(31, 17));
         default: v[4:0] = 5'($urandom_range(4, 1));
      endcase
      return v;
   endfunction

   function automatic logic [10:0] random_dim(int unsigned small_max);
      logic [10:0] v;
      case ($urandom_range(9))
         0:       v = 11'd0;
         1:       v = DIM_MAX;
         2:       v = 11'($urandom_range(2047, 1025));
         default: v = 11'($urandom_range(small_max, 1));
      endcase
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("pixel %0d %s: got %h, want %h",
                                   pixels_checked, name, got, want));
   endtask

   task automatic check_output();
      out_pixel_type want;
      if (pending_pixels.size() == 0) begin
         report_mismatch($sformatf("pixel %0d arrived with none pending", pixels_checked));
      end else begin
         want = pending_pixels.pop_front();
         check_field("red_out",   rsp_red_out,   want.red);
         check_field("green_out", rsp_green_out, want.green);
         check_field("blue_out",  rsp_blue_out,  want.blue);
         check_field("is_grout",  8'(rsp_is_grout),  8'(want.grout));
         check_field("row_end",   8'(rsp_row_end),   8'(want.row_end));
         check_field("frame_end", 8'(rsp_frame_end), 8'(want.frame_end));
      end
      pixels_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_output();
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // One request transaction; the prediction is made at the accepting edge.
   task automatic send_item(logic mode, logic [9:0] col, logic [23:0] rgb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_column   <= col;
      req_red_in   <= rgb[23:16];
      req_green_in <= rgb[15:8];
      req_blue_in  <= rgb[7:0];
      do @(posedge clock); while (req_stall);
      if (mode == MODE_EMIT) begin
         pending_pixels.push_back(advance_output_pixel());
         items_sent++;
      end else if (col < width_eff()) begin
         source_row[col] = rgb;
         row_loaded[col] = 1'b1;
         items_sent++;
      end
   endtask

   // Emits one pixel, first loading the column about to be read if it was never written.
   task automatic emit_pixel();
      if (!row_loaded[col_src]) send_item(MODE_LOAD, col_src[9:0], 24'($urandom()));
      send_item(MODE_EMIT, 10'($urandom()), 24'($urandom()));
   endtask

   task automatic wait_for_results(int unsigned settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [10:0] data);
      wait_for_results(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TILE_SIZE:  cfg_tile   = data[4:0];
         CSR_SRC_WIDTH:  cfg_width  = data;
         CSR_SRC_HEIGHT: cfg_height = data;
         default: ;
      endcase
      if (idx != CSR_UNUSED) restart_frame();
   endtask

   task automatic test_reset_state();
      repeat (2) emit_pixel();
   endtask

   // Tile 3 over a 2 x 1 source: one row of colour pixels between borders,
   // a dropped load past the width, then the wrap into the next frame.
   task automatic test_small_frame();
      write_register(CSR_TILE_SIZE, 11'd3);
      write_register(CSR_SRC_WIDTH, 11'd2);
      write_register(CSR_SRC_HEIGHT, 11'd1);
      send_item(MODE_LOAD, 10'd0, 24'hFFFFFF);
      send_item(MODE_LOAD, 10'd1, 24'h000000);
      send_item(MODE_LOAD, 10'd1023, 24'h5A3CC3);
      repeat (20) emit_pixel();
   endtask

   task automatic test_clamped_config();
      write_register(CSR_TILE_SIZE, 11'h7E0);
      write_register(CSR_SRC_WIDTH, 11'd0);
      write_register(CSR_SRC_HEIGHT, 11'h7FF);
      repeat (3) emit_pixel();
   endtask

   task automatic test_unused_register();
      write_register(CSR_UNUSED, 11'h7FF);
      repeat (2) emit_pixel();
   endtask

   task automatic test_random_traffic();
      int unsigned budget, pause_at, n, c, w, base;
      bit          unused_write;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 25;
            recv_idle_pct = 82;
         end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 82;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_register(CSR_TILE_SIZE, random_tile_word());
         write_register(CSR_SRC_WIDTH, random_dim(6));
         write_register(CSR_SRC_HEIGHT, random_dim(4));
         budget       = $urandom_range(120, 60);
         pause_at     = $urandom_range(budget - 1);
         unused_write = ($urandom_range(3) == 0);
         for (n = 0; n < budget; n++) begin
            if (n == pause_at) begin
               if (unused_write) write_register(CSR_UNUSED, 11'($urandom()));
               else wait_for_results(0);
            end
            // usually a fresh source row at the start of a band of k output rows, if the width is at most 16
            if (pos_col == 0 && ph_row == 0 && width_eff() <= 16 && $urandom_range(9) != 0) begin
               w    = width_eff();
               base = $urandom_range(w - 1);
               for (c = 0; c < w; c++)
                  send_item(MODE_LOAD, 10'((base + c) % w), 24'($urandom()));
            end
            if ($urandom_range(9) == 0)
               send_item(MODE_LOAD,
                         ($urandom_range(3) == 0) ? 10'd1023 : 10'($urandom_range(1023)),
                         24'($urandom()));
            else
               emit_pixel();
         end
      end
   endtask

   initial begin
      cfg_tile   = TILE_RESET;
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_small_frame();
      test_clamped_config();
      test_unused_register();
      test_random_traffic();
      wait_for_results(SETTLE_CYCLES);
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
